### hw/rtl/bba_pkg.sv
package bba_pkg;

   // Field and word widths
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;
   localparam int LIM_W  = 6;
   localparam int REF_W  = 16;
   localparam int ACT_W  = 2;
   localparam int ST_W   = 2;
   localparam int CNT_W  = 8;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // Register reset values
   localparam logic [REF_W-1:0] OFFSET_RESET = 16'd3;
   localparam logic [CNT_W-1:0] COUNT_RESET  = 8'd128;

   // Register select (paddr bit 2)
   localparam logic REG_OFFSET = 1'b0;
   localparam logic REG_COUNT  = 1'b1;

   // Request actions
   localparam logic [ACT_W-1:0] ACT_ALLOC     = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FREE      = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RESET_MAP = 2'd2;

   // Response status codes
   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

   // Result of the free-bit search over one map word
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } scan_res_type;

endpackage

### hw/rtl/bba_ram.sv
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bba_scan.sv
module bba_scan (
   input  logic [bba_pkg::WORD_W-1:0] word,
   input  logic [bba_pkg::LIM_W-1:0]  lim,
   output bba_pkg::scan_res_type      res
);
   import bba_pkg::*;

   logic [WORD_W-1:0] avail;

   // Mark clear bits below the limit
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         avail[i] = !word[i] && (LIM_W'(i) < lim);
      end
   end

   // Pick the lowest marked bit
   always_comb begin
      res.found = |avail;
      res.pos   = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (avail[i]) begin
            res.pos = BIT_W'(i);
         end
      end
   end

endmodule

### hw/rtl/bitmap_block_allocator.sv
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | req_action, req_block_ref
// rsp     | out       | rsp_valid / rsp_stall  | rsp_allocated_ref, rsp_status
// csr     | in/out    | psel, penable, pready  | paddr, pwdata, prdata
//
// One request at a time. For an allocate the response register loads in the finish
// step, after the decode step and the search of the 32-bit map words (at most 4 for 128
// blocks); the map RAM read port feeds one word per cycle to the free-bit search.
// A free passes through decode and modify before finish; reset-map, allocate with no
// managed blocks, an out-of-range free and the undefined action go from decode
// straight to finish. The sequencer returns to idle before the next accept.
// Reset clears the map through per-word valid bits.
// A stalled response holds in the output register; the next request is
// taken meanwhile and waits in the finish step until the register frees.
module bitmap_block_allocator #(
   parameter int MAX_BLOCKS = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bba_pkg::ACT_W-1:0]   req_action,
   input  logic [bba_pkg::REF_W-1:0]   req_block_ref,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bba_pkg::REF_W-1:0]   rsp_allocated_ref,
   output logic [bba_pkg::ST_W-1:0]    rsp_status,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bba_pkg::ADDR_W-1:0]  paddr,
   input  logic [bba_pkg::DATA_W-1:0]  pwdata,
   output logic [bba_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import bba_pkg::*;

   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IW        = (AW + BIT_W >= CNT_W + 1) ? AW + BIT_W : CNT_W + 1;
   localparam int MAXC      = (MAX_BLOCKS > 255) ? 255 : MAX_BLOCKS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_MODIFY,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [ACT_W-1:0]      act_ff, act_in;
   logic [REF_W-1:0]      ref_ff, ref_in;
   logic [AW-1:0]         sp_ff, sp_in;
   logic [BIT_W-1:0]      fbit_ff, fbit_in;
   logic [REF_W-1:0]      res_ref_ff, res_ref_in;
   logic [ST_W-1:0]       res_st_ff, res_st_in;
   logic [MAP_WORDS-1:0]  vld_ff, vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [REF_W-1:0]      rsp_ref_ff, rsp_ref_in;
   logic [ST_W-1:0]       rsp_st_ff, rsp_st_in;
   logic [REF_W-1:0]      off_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic [CNT_W-1:0]      eff_cnt;
   logic [REF_W:0]        diff;
   logic [REF_W-1:0]      idx;
   logic                  out_of_range;
   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [WORD_W-1:0]     wr_data, rd_data, cur_word;
   logic [IW-1:0]         base, rem, aidx;
   logic [LIM_W-1:0]      lim;
   logic                  last_word;
   scan_res_type          scan_res;
   logic                  cfg_wr;

   // Configuration registers
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= OFFSET_RESET;
         cnt_ff <= COUNT_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[2])
            REG_OFFSET: off_ff <= pwdata[REF_W-1:0];
            REG_COUNT:  cnt_ff <= pwdata[CNT_W-1:0];
            default:    off_ff <= off_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_OFFSET: prdata = DATA_W'(off_ff);
         REG_COUNT:  prdata = DATA_W'(cnt_ff);
         default:    prdata = '0;
      endcase
   end

   // Saturate block count at MAX_BLOCKS, capped at 255
   assign eff_cnt = (cnt_ff > CNT_W'(MAXC)) ? CNT_W'(MAXC) : cnt_ff;

   // Free reference range check
   assign diff         = {1'b0, ref_ff} - {1'b0, off_ff};
   assign idx          = diff[REF_W-1:0];
   assign out_of_range = diff[REF_W] || (idx >= REF_W'(eff_cnt));

   // Map word storage; a word never written since the last clear reads as zero
   bba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAP_WORDS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cur_word = vld_ff[sp_ff] ? rd_data : '0;

   // Bits of the current word that lie below the block count
   assign base      = IW'({sp_ff, BIT_W'(0)});
   assign rem       = IW'(eff_cnt) - base;
   assign lim       = (rem >= IW'(WORD_W)) ? LIM_W'(WORD_W) : LIM_W'(rem);
   assign last_word = (rem <= IW'(WORD_W));

   bba_scan u_scan (
      .word (cur_word),
      .lim  (lim),
      .res  (scan_res)
   );

   assign aidx = base + IW'(scan_res.pos);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      ref_in       = ref_ff;
      sp_in        = sp_ff;
      fbit_in      = fbit_ff;
      res_ref_in   = res_ref_ff;
      res_st_in    = res_st_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ref_in   = rsp_ref_ff;
      rsp_st_in    = rsp_st_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = sp_ff;
      wr_data      = cur_word;

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               ref_in   = req_block_ref;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_ref_in = '0;
            res_st_in  = ST_DONE;
            state_in   = S_FINISH;
            priority if (act_ff == ACT_ALLOC) begin
               if (eff_cnt == '0) begin
                  res_st_in = ST_FULL;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  sp_in    = '0;
                  state_in = S_SCAN;
               end
            end else if (act_ff == ACT_FREE) begin
               if (out_of_range) begin
                  res_st_in = ST_RANGE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(idx >> BIT_W);
                  sp_in    = AW'(idx >> BIT_W);
                  fbit_in  = idx[BIT_W-1:0];
                  state_in = S_MODIFY;
               end
            end else if (act_ff == ACT_RESET_MAP) begin
               vld_in    = '0;
               vld_in[0] = 1'b1;
               wr_en     = 1'b1;
               wr_addr   = '0;
               wr_data   = WORD_W'(1);
            end else begin
               res_st_in = ST_DONE;
            end
         end
         S_SCAN: begin
            if (scan_res.found) begin
               wr_en         = 1'b1;
               wr_data       = cur_word | (WORD_W'(1) << scan_res.pos);
               vld_in[sp_ff] = 1'b1;
               res_ref_in    = off_ff + REF_W'(aidx);
               res_st_in     = ST_DONE;
               state_in      = S_FINISH;
            end else if (last_word) begin
               res_ref_in = '0;
               res_st_in  = ST_FULL;
               state_in   = S_FINISH;
            end else begin
               rd_en   = 1'b1;
               rd_addr = sp_ff + AW'(1);
               sp_in   = sp_ff + AW'(1);
            end
         end
         S_MODIFY: begin
            wr_en         = 1'b1;
            wr_data       = cur_word & ~(WORD_W'(1) << fbit_ff);
            vld_in[sp_ff] = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            // Hold until the output register frees
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ref_in   = res_ref_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff     <= act_in;
      ref_ff     <= ref_in;
      sp_ff      <= sp_in;
      fbit_ff    <= fbit_in;
      res_ref_ff <= res_ref_in;
      res_st_ff  <= res_st_in;
      rsp_ref_ff <= rsp_ref_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_allocated_ref = rsp_ref_ff;
   assign rsp_status        = rsp_st_ff;

endmodule

### hw/rtl/bba_checker.sv
module bba_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [bba_pkg::REF_W-1:0]   rsp_allocated_ref,
   input logic [bba_pkg::ST_W-1:0]    rsp_status
);
   import bba_pkg::*;

   // Stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_allocated_ref)
         && $stable(rsp_status))
      else $error("stalled response changed");

   // Only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_FULL
         || rsp_status == ST_RANGE))
      else $error("undefined response status");

   // Failed requests give out no block
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_allocated_ref == '0)
      else $error("nonzero block on failed request");

   // An accepted request blocks the next beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_allocated_ref (rsp_allocated_ref),
   .rsp_status        (rsp_status)
);
